// ===== sv/latency_histogram_collector_defines.svh =====
// Assertion macros shared by the latency histogram collector modules.
`ifndef LATENCY_HISTOGRAM_COLLECTOR_DEFINES_SVH
`define LATENCY_HISTOGRAM_COLLECTOR_DEFINES_SVH

`ifndef SYNTHESIS
`define LHC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("lhc assertion failed");
`define LHC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("lhc assertion failed");
`else
`define LHC_ASSERT_IMP(lbl, ante, cons)
`define LHC_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ===== sv/lhc_pkg.sv =====
`timescale 1ns / 1ps

package lhc_pkg;

  localparam int unsigned BUCKETS_DEF = 167;
  localparam int unsigned TABLE_LEN   = 167;
  localparam int unsigned QDEPTH      = 2;
  localparam int unsigned IN_W        = 176;
  localparam int unsigned OUT_W       = 648;

  localparam logic [63:0] NS_PER_US = 64'd1000;
  localparam logic [63:0] NS_PER_S  = NS_PER_US * 64'd1000 * 64'd1000;

  typedef enum logic [1:0] {
    CMD_RECORD = 2'd0,
    CMD_CLOSE  = 2'd1,
    CMD_READ   = 2'd2
  } cmd_e;

  typedef logic [63:0] bound_arr_t [TABLE_LEN];

  localparam logic [63:0] DECADE_STEP [16] = '{
    64'd12, 64'd14, 64'd16, 64'd18, 64'd20, 64'd25, 64'd30, 64'd35,
    64'd40, 64'd45, 64'd50, 64'd60, 64'd70, 64'd80, 64'd90, 64'd100
  };

  function automatic bound_arr_t build_bounds();
    bound_arr_t  b;
    logic [63:0] m;
    int          d;
    int          k;
    b[0] = 64'd9;
    m    = 64'd1;
    for (d = 0; d < 10; d++) begin
      for (k = 0; k < 16; k++) begin
        b[1 + d * 16 + k] = m * DECADE_STEP[k];
      end
      m = m * 64'd10;
    end
    b[161] = NS_PER_S * 64'd300;
    b[162] = NS_PER_S * 64'd1800;
    b[163] = NS_PER_S * 64'd14400;
    b[164] = NS_PER_S * 64'd28800;
    b[165] = NS_PER_S * 64'd86400;
    b[166] = '1;
    return b;
  endfunction

  localparam bound_arr_t BOUNDS = build_bounds();

  // Boundaries beyond the table read as all ones.
  function automatic logic [63:0] boundary(input logic [7:0] idx);
    return (32'(idx) < TABLE_LEN) ? BOUNDS[idx] : '1;
  endfunction

  typedef struct packed {
    logic [1:0]  cmd;
    logic [63:0] lat;
    logic [63:0] sq;
    logic [31:0] volume;
    logic [7:0]  addr;
    logic        in_range;
  } op_t;

  // First field in the highest bits.
  typedef struct packed {
    logic [63:0] total_count;
    logic [63:0] bucket_count;
    logic [7:0]  bucket_hit;
    logic [63:0] overall_max;
    logic [63:0] overall_min;
    logic [63:0] interval_max;
    logic [63:0] interval_min;
    logic [63:0] interval_volume;
    logic [63:0] interval_square_sum;
    logic [63:0] interval_latency_sum;
    logic [63:0] interval_count;
  } res_t;

endpackage

// ===== sv/lhc_front.sv =====
`timescale 1ns / 1ps

module lhc_front #(
  parameter int unsigned BUCKETS = lhc_pkg::BUCKETS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_valid_i,
  output logic              s_ready_o,
  input  logic [1:0]        command_i,
  input  logic [63:0]       start_time_i,
  input  logic [63:0]       end_time_i,
  input  logic [31:0]       volume_i,
  input  logic [7:0]        bucket_index_i,
  output logic              push_o,
  output lhc_pkg::op_t      op_o,
  input  logic              full_i
);

  localparam int unsigned IDX_W = $clog2(BUCKETS);
  localparam logic [IDX_W-1:0] LAST = IDX_W'(BUCKETS - 1);
  localparam logic [IDX_W-1:0] TOP  = IDX_W'(1) << (IDX_W - 1);

  typedef enum logic {F_IDLE, F_WORK} state_e;
  typedef enum logic [1:0] {MP_LL, MP_LH, MP_ADD, MP_DONE} mul_ph_e;

  state_e           state_q;
  mul_ph_e          mul_ph_q;
  lhc_pkg::op_t     op_q;
  logic [IDX_W-1:0] n_q;
  logic [IDX_W-1:0] probe_q;
  logic [63:0]      prod_q;
  logic [63:0]      sq_q;

  logic [IDX_W-1:0] try_w;
  logic             take;
  logic [31:0]      mul_b;
  logic [63:0]      prod;
  logic             done;
  logic             accept;

  assign s_ready_o = (state_q == F_IDLE);
  assign accept    = s_valid_i && s_ready_o;

  assign try_w = n_q | probe_q;
  assign take  = (try_w <= LAST) &&
                 (lhc_pkg::boundary(8'(try_w) - 8'd1) < op_q.lat);

  assign mul_b = (mul_ph_q == MP_LL) ? op_q.lat[31:0] : op_q.lat[63:32];
  assign prod  = op_q.lat[31:0] * mul_b;

  assign done   = (state_q == F_WORK) && (probe_q == '0) && (mul_ph_q == MP_DONE);
  assign push_o = done && !full_i;

  always_comb begin
    op_o = op_q;
    op_o.sq = sq_q;
    if (op_q.cmd == lhc_pkg::CMD_RECORD) begin
      op_o.addr = 8'(n_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= F_IDLE;
      mul_ph_q <= MP_DONE;
      op_q     <= '0;
      n_q      <= '0;
      probe_q  <= '0;
      prod_q   <= '0;
      sq_q     <= '0;
    end else begin
      unique case (state_q)
        F_IDLE: begin
          if (accept) begin
            op_q.cmd      <= command_i;
            op_q.lat      <= end_time_i - start_time_i;
            op_q.sq       <= '0;
            op_q.volume   <= volume_i;
            op_q.addr     <= bucket_index_i;
            op_q.in_range <= ({1'b0, bucket_index_i} < 9'(BUCKETS));
            n_q           <= '0;
            sq_q          <= '0;
            if (command_i == lhc_pkg::CMD_RECORD) begin
              probe_q  <= TOP;
              mul_ph_q <= MP_LL;
            end else begin
              probe_q  <= '0;
              mul_ph_q <= MP_DONE;
            end
            state_q <= F_WORK;
          end
        end
        F_WORK: begin
          if (probe_q != '0) begin
            if (take) begin
              n_q <= try_w;
            end
            probe_q <= probe_q >> 1;
          end
          unique case (mul_ph_q)
            MP_LL: begin
              prod_q   <= prod;
              mul_ph_q <= MP_LH;
            end
            MP_LH: begin
              sq_q     <= prod_q;
              prod_q   <= prod;
              mul_ph_q <= MP_ADD;
            end
            MP_ADD: begin
              sq_q     <= sq_q + {prod_q[30:0], 33'b0};
              mul_ph_q <= MP_DONE;
            end
            MP_DONE: begin
              mul_ph_q <= MP_DONE;
            end
            default: begin
              mul_ph_q <= MP_DONE;
            end
          endcase
          if (push_o) begin
            state_q <= F_IDLE;
          end
        end
        default: begin
          state_q <= F_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== sv/lhc_queue.sv =====
`timescale 1ns / 1ps

`include "latency_histogram_collector_defines.svh"

module lhc_queue (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  lhc_pkg::op_t data_i,
  output logic         full_o,
  output logic         valid_o,
  output lhc_pkg::op_t data_o,
  input  logic         pop_i
);

  localparam int unsigned PTR_W = $clog2(lhc_pkg::QDEPTH);
  localparam int unsigned CNT_W = $clog2(lhc_pkg::QDEPTH + 1);

  lhc_pkg::op_t     entry_q [lhc_pkg::QDEPTH];
  logic [PTR_W-1:0] wr_ptr_q;
  logic [PTR_W-1:0] rd_ptr_q;
  logic [CNT_W-1:0] cnt_q;
  logic             do_push;
  logic             do_pop;

  assign full_o  = (cnt_q == CNT_W'(lhc_pkg::QDEPTH));
  assign valid_o = (cnt_q != '0);
  assign data_o  = entry_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  `LHC_ASSERT_IMP(a_push_not_full, push_i, !full_o)
  `LHC_ASSERT_IMP(a_pop_not_empty, pop_i, valid_o)
  `LHC_ASSERT_IMP(a_cnt_bound, 1'b1, cnt_q <= CNT_W'(lhc_pkg::QDEPTH))

endmodule

// ===== sv/lhc_back.sv =====
`timescale 1ns / 1ps

`include "latency_histogram_collector_defines.svh"

module lhc_back #(
  parameter int unsigned BUCKETS = lhc_pkg::BUCKETS_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          q_valid_i,
  input  lhc_pkg::op_t  q_op_i,
  output logic          q_pop_o,
  output logic          m_valid_o,
  input  logic          m_ready_i,
  output lhc_pkg::res_t res_o
);

  localparam int unsigned IDX_W = $clog2(BUCKETS);

  typedef enum logic {B_IDLE, B_WAIT} state_e;

  state_e        state_q;
  logic          m_valid_q;
  lhc_pkg::res_t res_q;
  logic [63:0]   total_q;
  logic [63:0]   iv_count_q;
  logic [63:0]   iv_lat_q;
  logic [63:0]   iv_sq_q;
  logic [63:0]   iv_vol_q;
  logic [63:0]   cur_min_q;
  logic [63:0]   cur_max_q;
  logic [63:0]   whole_min_q;
  logic [63:0]   whole_max_q;

  logic [63:0]   mem_q [BUCKETS];
  logic [BUCKETS-1:0] vld_q;
  logic [63:0]   rd_data_q;
  logic          rd_vld_q;

  logic             is_rec;
  logic             is_rd;
  logic             is_close;
  logic             needs_mem;
  logic             out_free;
  logic             fire;
  logic             rd_en;
  logic [IDX_W-1:0] addr;
  logic [63:0]      cnt;
  logic [63:0]      new_cnt;
  logic [63:0]      nmin;
  logic [63:0]      nmax;
  logic [63:0]      wmin;
  logic [63:0]      wmax;
  lhc_pkg::res_t    res_d;

  assign is_rec    = (q_op_i.cmd == lhc_pkg::CMD_RECORD);
  assign is_rd     = (q_op_i.cmd == lhc_pkg::CMD_READ);
  assign is_close  = (q_op_i.cmd == lhc_pkg::CMD_CLOSE);
  assign needs_mem = is_rec || (is_rd && q_op_i.in_range);
  assign out_free  = !m_valid_q || m_ready_i;
  assign rd_en     = (state_q == B_IDLE) && q_valid_i && needs_mem;
  assign fire      = ((state_q == B_IDLE) && q_valid_i && !needs_mem && out_free) ||
                     ((state_q == B_WAIT) && out_free);
  assign q_pop_o   = fire;
  assign addr      = q_op_i.addr[IDX_W-1:0];

  assign cnt     = rd_vld_q ? rd_data_q : '0;
  assign new_cnt = cnt + 64'd1;
  assign nmin    = (cur_min_q > q_op_i.lat) ? q_op_i.lat : cur_min_q;
  assign nmax    = (cur_max_q < q_op_i.lat) ? q_op_i.lat : cur_max_q;
  assign wmin    = (whole_min_q > cur_min_q) ? cur_min_q : whole_min_q;
  assign wmax    = (whole_max_q < cur_max_q) ? cur_max_q : whole_max_q;

  always_comb begin
    res_d.interval_count       = iv_count_q;
    res_d.interval_latency_sum = iv_lat_q;
    res_d.interval_square_sum  = iv_sq_q;
    res_d.interval_volume      = iv_vol_q;
    res_d.interval_min         = cur_min_q;
    res_d.interval_max         = cur_max_q;
    res_d.overall_min          = whole_min_q;
    res_d.overall_max          = whole_max_q;
    res_d.bucket_hit           = '0;
    res_d.bucket_count         = '0;
    res_d.total_count          = total_q;
    if (is_rec) begin
      res_d.interval_count       = iv_count_q + 64'd1;
      res_d.interval_latency_sum = iv_lat_q + q_op_i.lat;
      res_d.interval_square_sum  = iv_sq_q + q_op_i.sq;
      res_d.interval_volume      = iv_vol_q + {32'b0, q_op_i.volume};
      res_d.interval_min         = nmin;
      res_d.interval_max         = nmax;
      res_d.bucket_hit           = q_op_i.addr;
      res_d.bucket_count         = new_cnt;
      res_d.total_count          = total_q + 64'd1;
    end else if (is_rd) begin
      res_d.bucket_count = q_op_i.in_range ? cnt : '0;
    end else if (is_close) begin
      res_d.overall_min = wmin;
      res_d.overall_max = wmax;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && is_rec) begin
      mem_q[addr] <= new_cnt;
    end
    if (rd_en) begin
      rd_data_q <= mem_q[addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (fire && is_rec) begin
        vld_q[addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_q <= vld_q[addr];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      m_valid_q   <= 1'b0;
      res_q       <= '0;
      total_q     <= '0;
      iv_count_q  <= '0;
      iv_lat_q    <= '0;
      iv_sq_q     <= '0;
      iv_vol_q    <= '0;
      cur_min_q   <= '1;
      cur_max_q   <= '0;
      whole_min_q <= '1;
      whole_max_q <= '0;
    end else begin
      if (fire) begin
        m_valid_q <= 1'b1;
        res_q     <= res_d;
      end else if (m_ready_i) begin
        m_valid_q <= 1'b0;
      end
      unique case (state_q)
        B_IDLE: begin
          if (rd_en) begin
            state_q <= B_WAIT;
          end
        end
        B_WAIT: begin
          if (fire) begin
            state_q <= B_IDLE;
          end
        end
        default: begin
          state_q <= B_IDLE;
        end
      endcase
      if (fire && is_rec) begin
        total_q    <= res_d.total_count;
        iv_count_q <= res_d.interval_count;
        iv_lat_q   <= res_d.interval_latency_sum;
        iv_sq_q    <= res_d.interval_square_sum;
        iv_vol_q   <= res_d.interval_volume;
        cur_min_q  <= nmin;
        cur_max_q  <= nmax;
      end else if (fire && is_close) begin
        whole_min_q <= wmin;
        whole_max_q <= wmax;
        cur_min_q   <= '1;
        cur_max_q   <= '0;
        iv_count_q  <= '0;
        iv_lat_q    <= '0;
        iv_sq_q     <= '0;
        iv_vol_q    <= '0;
      end
    end
  end

  assign m_valid_o = m_valid_q;
  assign res_o     = res_q;

  `LHC_ASSERT_IMP(a_pop_valid, q_pop_o, q_valid_i)
  `LHC_ASSERT_IMP(a_wait_mem, state_q == B_WAIT, q_valid_i && needs_mem)
  `LHC_ASSERT_NEXT(a_close_clears, fire && is_close, cur_min_q == '1 && cur_max_q == '0)

endmodule

// ===== sv/latency_histogram_collector.sv =====
`timescale 1ns / 1ps

// Channel   Direction  tdata fields (lowest bit up)
// s_*       in         command, start_time, end_time, volume, bucket_index
// m_*       out        eleven result figures, interval_count first
//
// A record transaction occupies the front end while the bit-per-cycle boundary
// search and the three-step square on one 32 by 32 multiplier run side by side,
// and until the queue takes it. Close, read and unused commands skip both. The
// back end registers the bucket count before it answers a bucket access and
// answers other commands without that read. Reset clears every figure and marks
// all buckets empty at once. Either side may stall; a two-entry queue between
// front and back end and the output register keep them apart.

module latency_histogram_collector #(
  parameter int unsigned BUCKETS = lhc_pkg::BUCKETS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       s_tvalid_i,
  output logic                       s_tready_o,
  // command[1:0], start_time[65:2], end_time[129:66], volume[161:130],
  // bucket_index[169:162], zero padding above.
  input  logic [lhc_pkg::IN_W-1:0]   s_tdata_i,
  output logic                       m_tvalid_o,
  input  logic                       m_tready_i,
  // interval_count, interval_latency_sum, interval_square_sum,
  // interval_volume, interval_min, interval_max, overall_min, overall_max
  // (64 bits each), bucket_hit (8 bits), bucket_count, total_count.
  output logic [lhc_pkg::OUT_W-1:0]  m_tdata_o
);

  logic          push;
  lhc_pkg::op_t  push_op;
  logic          full;
  logic          q_valid;
  lhc_pkg::op_t  q_op;
  logic          q_pop;
  lhc_pkg::res_t res;

  lhc_front #(
    .BUCKETS(BUCKETS)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_valid_i     (s_tvalid_i),
    .s_ready_o     (s_tready_o),
    .command_i     (s_tdata_i[1:0]),
    .start_time_i  (s_tdata_i[65:2]),
    .end_time_i    (s_tdata_i[129:66]),
    .volume_i      (s_tdata_i[161:130]),
    .bucket_index_i(s_tdata_i[169:162]),
    .push_o        (push),
    .op_o          (push_op),
    .full_i        (full)
  );

  lhc_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (push_op),
    .full_o (full),
    .valid_o(q_valid),
    .data_o (q_op),
    .pop_i  (q_pop)
  );

  lhc_back #(
    .BUCKETS(BUCKETS)
  ) u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .q_valid_i(q_valid),
    .q_op_i   (q_op),
    .q_pop_o  (q_pop),
    .m_valid_o(m_tvalid_o),
    .m_ready_i(m_tready_i),
    .res_o    (res)
  );

  assign m_tdata_o = res;

endmodule
